// File: rtl/tslg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tslg_pkg;

    localparam int TEMP_BITS_DEF  = 16;
    localparam int WIDTH_BITS_DEF = 16;
    localparam int FIELD_W        = 16;
    localparam int KIND_W         = 2;
    localparam int SLOPE_W        = 48;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [KIND_W-1:0] KIND_INTERIOR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VACUUM   = 2'd1;

    // Case selected by the front end for each item.
    localparam logic [1:0] CLS_ZERO     = 2'd0;
    localparam logic [1:0] CLS_LOW_VAC  = 2'd1;
    localparam logic [1:0] CLS_HIGH_VAC = 2'd2;
    localparam logic [1:0] CLS_INTERIOR = 2'd3;

    typedef struct packed {
        logic [1:0] cls;
        logic       neg_a;
        logic       neg_b;
    } ctl_t;

    // Quotient width of the rounded division (mag + den * 2^14) / (den * 2^15).
    function automatic int quo_bits(input int tb, input int wb);
        int t4w;
        int dsh;
        int nw;
        t4w = 4 * tb;
        dsh = wb + 1 + 14;
        nw  = ((t4w > dsh) ? t4w : dsh) + 1;
        return nw - 15;
    endfunction

endpackage

`default_nettype wire

// File: rtl/t4_slope_limited_gradient.sv
`timescale 1ns / 1ps
`default_nettype none

// Slope of T^4 across one mesh cell along one axis, with vacuum limiting.
// Input channel s_*: one cell per transfer, with the temperatures and widths of the
// cell and both neighbors and the kind of each side. Result channel m_*: one
// signed Q23.24 slope and a saturation flag per input, in input order.
// Throughput is one item per cycle while m_ready keeps the output moving. QW =
// max(4*TEMP_BITS, WIDTH_BITS + 15) - 14 is the number of stages in each of the
// two restoring dividers.
// The front end (two multiplier stages and the case selection) feeds a four-entry
// queue; the back end (dividers, limiting, rounding and saturation) drains it.
// When m_ready is low with a result presented, the back end holds its pipeline
// and its output register, the queue fills, and s_ready drops once the queue is
// full and the front end holds an item. The block holds no state between items.
// Reset is synchronous and active low; it empties the queue and clears all valid
// flags, so no result is presented until new inputs arrive.
module t4_slope_limited_gradient #(
    parameter int TEMP_BITS  = tslg_pkg::TEMP_BITS_DEF,
    parameter int WIDTH_BITS = tslg_pkg::WIDTH_BITS_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [tslg_pkg::FIELD_W-1:0]  s_cell_temp,
    input  wire  [tslg_pkg::FIELD_W-1:0]  s_low_temp,
    input  wire  [tslg_pkg::FIELD_W-1:0]  s_high_temp,
    input  wire  [tslg_pkg::FIELD_W-1:0]  s_cell_width,
    input  wire  [tslg_pkg::FIELD_W-1:0]  s_low_width,
    input  wire  [tslg_pkg::FIELD_W-1:0]  s_high_width,
    input  wire  [tslg_pkg::KIND_W-1:0]   s_low_kind,
    input  wire  [tslg_pkg::KIND_W-1:0]   s_high_kind,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [tslg_pkg::SLOPE_W-1:0]  m_slope,
    output logic                          m_saturated
);

    localparam int T4W   = 4 * TEMP_BITS;
    localparam int DB    = WIDTH_BITS + 1;
    localparam int CTW   = $bits(tslg_pkg::ctl_t);
    localparam int QDW   = CTW + 2 * T4W + 2 * DB;

    logic           push, pop, fifo_full, fifo_empty;
    tslg_pkg::ctl_t f_ctl, b_ctl;
    logic [T4W-1:0] f_mag_a, f_mag_b, b_mag_a, b_mag_b;
    logic [DB-1:0]  f_den_a, f_den_b, b_den_a, b_den_b;
    logic [QDW-1:0] q_wdata, q_rdata;

    tslg_front #(.TEMP_BITS(TEMP_BITS), .WIDTH_BITS(WIDTH_BITS)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_temp  (s_cell_temp),
        .s_low_temp   (s_low_temp),
        .s_high_temp  (s_high_temp),
        .s_cell_width (s_cell_width),
        .s_low_width  (s_low_width),
        .s_high_width (s_high_width),
        .s_low_kind   (s_low_kind),
        .s_high_kind  (s_high_kind),
        .fifo_full    (fifo_full),
        .push         (push),
        .ctl          (f_ctl),
        .mag_a        (f_mag_a),
        .den_a        (f_den_a),
        .mag_b        (f_mag_b),
        .den_b        (f_den_b)
    );

    assign q_wdata = {f_ctl, f_mag_a, f_den_a, f_mag_b, f_den_b};

    tslg_fifo #(.DATA_W(QDW), .DEPTH(tslg_pkg::FIFO_DEPTH)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   (q_wdata),
        .pop     (pop),
        .rdata   (q_rdata),
        .empty   (fifo_empty),
        .full    (fifo_full)
    );

    assign {b_ctl, b_mag_a, b_den_a, b_mag_b, b_den_b} = q_rdata;

    tslg_back #(.TEMP_BITS(TEMP_BITS), .WIDTH_BITS(WIDTH_BITS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fifo_empty  (fifo_empty),
        .pop         (pop),
        .ctl         (b_ctl),
        .mag_a       (b_mag_a),
        .den_a       (b_den_a),
        .mag_b       (b_mag_b),
        .den_b       (b_den_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_slope     (m_slope),
        .m_saturated (m_saturated)
    );

    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_slope == {1'b0, {(tslg_pkg::SLOPE_W - 1){1'b1}}} ||
             m_slope == {1'b1, {(tslg_pkg::SLOPE_W - 1){1'b0}}}))
        else $error("saturation flag set on a slope that is not at a range limit");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> fifo_full)
        else $error("input stalled while the queue has room");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_empty |-> !pop)
        else $error("queue popped while empty");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_slope) && $stable(m_saturated)))
        else $error("result changed while the receiver stalled");

endmodule

`default_nettype wire

// File: rtl/tslg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tslg_front #(
    parameter int TEMP_BITS  = tslg_pkg::TEMP_BITS_DEF,
    parameter int WIDTH_BITS = tslg_pkg::WIDTH_BITS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [tslg_pkg::FIELD_W-1:0]      s_cell_temp,
    input  wire  [tslg_pkg::FIELD_W-1:0]      s_low_temp,
    input  wire  [tslg_pkg::FIELD_W-1:0]      s_high_temp,
    input  wire  [tslg_pkg::FIELD_W-1:0]      s_cell_width,
    input  wire  [tslg_pkg::FIELD_W-1:0]      s_low_width,
    input  wire  [tslg_pkg::FIELD_W-1:0]      s_high_width,
    input  wire  [tslg_pkg::KIND_W-1:0]       s_low_kind,
    input  wire  [tslg_pkg::KIND_W-1:0]       s_high_kind,
    input  wire                               fifo_full,
    output logic                              push,
    output tslg_pkg::ctl_t                    ctl,
    output logic [4*TEMP_BITS-1:0]            mag_a,
    output logic [WIDTH_BITS:0]               den_a,
    output logic [4*TEMP_BITS-1:0]            mag_b,
    output logic [WIDTH_BITS:0]               den_b
);

    localparam int SQW = 2 * TEMP_BITS;
    localparam int T4W = 4 * TEMP_BITS;
    localparam int DB  = WIDTH_BITS + 1;

    function automatic logic [WIDTH_BITS-1:0] wfix(input logic [tslg_pkg::FIELD_W-1:0] w);
        logic [2*tslg_pkg::FIELD_W-1:0] wide;
        logic [WIDTH_BITS-1:0]          m;
        wide = {{tslg_pkg::FIELD_W{1'b0}}, w};
        m    = wide[WIDTH_BITS-1:0];
        return (m == '0) ? WIDTH_BITS'(1) : m;
    endfunction

    logic                          en;
    logic                          a_valid_reg, b_valid_reg;
    logic [SQW-1:0]                a_sqc_reg, a_sql_reg, a_sqh_reg;
    logic [T4W-1:0]                b_t4c_reg, b_t4l_reg, b_t4h_reg;
    logic [WIDTH_BITS-1:0]         a_wc_reg, a_wl_reg, a_wh_reg;
    logic [WIDTH_BITS-1:0]         b_wc_reg, b_wl_reg, b_wh_reg;
    logic [tslg_pkg::KIND_W-1:0]   a_lk_reg, a_hk_reg, b_lk_reg, b_hk_reg;

    assign en      = !b_valid_reg || !fifo_full;
    assign s_ready = en;
    assign push    = b_valid_reg && !fifo_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_sqc_reg <= s_cell_temp[TEMP_BITS-1:0] * s_cell_temp[TEMP_BITS-1:0];
            a_sql_reg <= s_low_temp[TEMP_BITS-1:0] * s_low_temp[TEMP_BITS-1:0];
            a_sqh_reg <= s_high_temp[TEMP_BITS-1:0] * s_high_temp[TEMP_BITS-1:0];
            a_wc_reg  <= wfix(s_cell_width);
            a_wl_reg  <= wfix(s_low_width);
            a_wh_reg  <= wfix(s_high_width);
            a_lk_reg  <= s_low_kind;
            a_hk_reg  <= s_high_kind;
            b_t4c_reg <= a_sqc_reg * a_sqc_reg;
            b_t4l_reg <= a_sql_reg * a_sql_reg;
            b_t4h_reg <= a_sqh_reg * a_sqh_reg;
            b_wc_reg  <= a_wc_reg;
            b_wl_reg  <= a_wl_reg;
            b_wh_reg  <= a_wh_reg;
            b_lk_reg  <= a_lk_reg;
            b_hk_reg  <= a_hk_reg;
        end
    end

    // Both orders of each difference are formed so the magnitude needs no negation.
    logic [T4W:0]   hs_fwd, hs_rev, ls_fwd, ls_rev;
    logic           hs_neg, ls_neg;
    logic [T4W-1:0] hs_mag, ls_mag;
    logic           lk_ok, hk_ok;
    logic [DB-1:0]  den_low, den_high;
    logic [1:0]     cls;

    assign hs_fwd   = {1'b0, b_t4h_reg} - {1'b0, b_t4c_reg};
    assign hs_rev   = {1'b0, b_t4c_reg} - {1'b0, b_t4h_reg};
    assign ls_fwd   = {1'b0, b_t4c_reg} - {1'b0, b_t4l_reg};
    assign ls_rev   = {1'b0, b_t4l_reg} - {1'b0, b_t4c_reg};
    assign hs_neg   = hs_fwd[T4W];
    assign ls_neg   = ls_fwd[T4W];
    assign hs_mag   = hs_neg ? hs_rev[T4W-1:0] : hs_fwd[T4W-1:0];
    assign ls_mag   = ls_neg ? ls_rev[T4W-1:0] : ls_fwd[T4W-1:0];
    assign den_low  = {1'b0, b_wc_reg} + {1'b0, b_wl_reg};
    assign den_high = {1'b0, b_wc_reg} + {1'b0, b_wh_reg};
    assign lk_ok    = (b_lk_reg == tslg_pkg::KIND_INTERIOR) ||
                      (b_lk_reg == tslg_pkg::KIND_VACUUM);
    assign hk_ok    = (b_hk_reg == tslg_pkg::KIND_INTERIOR) ||
                      (b_hk_reg == tslg_pkg::KIND_VACUUM);

    always_comb begin
        if (!lk_ok || !hk_ok) begin
            cls = tslg_pkg::CLS_ZERO;
        end else if (b_lk_reg == tslg_pkg::KIND_VACUUM &&
                     b_hk_reg == tslg_pkg::KIND_VACUUM) begin
            cls = tslg_pkg::CLS_ZERO;
        end else if (b_lk_reg == tslg_pkg::KIND_VACUUM) begin
            cls = tslg_pkg::CLS_LOW_VAC;
        end else if (b_hk_reg == tslg_pkg::KIND_VACUUM) begin
            cls = tslg_pkg::CLS_HIGH_VAC;
        end else begin
            cls = tslg_pkg::CLS_INTERIOR;
        end
    end

    // Divider A takes the high-side slope when the low side is vacuum, else the low-side one.
    // Divider B takes the high-side slope for two interior sides, else the vacuum limit.
    always_comb begin
        ctl.cls = cls;
        if (cls == tslg_pkg::CLS_LOW_VAC) begin
            mag_a     = hs_mag;
            ctl.neg_a = hs_neg;
            den_a     = den_high;
        end else begin
            mag_a     = ls_mag;
            ctl.neg_a = ls_neg;
            den_a     = den_low;
        end
        if (cls == tslg_pkg::CLS_INTERIOR) begin
            mag_b     = hs_mag;
            ctl.neg_b = hs_neg;
            den_b     = den_high;
        end else begin
            mag_b     = b_t4c_reg;
            ctl.neg_b = 1'b0;
            den_b     = {1'b0, b_wc_reg};
        end
    end

endmodule

`default_nettype wire

// File: rtl/tslg_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module tslg_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = tslg_pkg::FIFO_DEPTH
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push,
    input  wire  [DATA_W-1:0] wdata,
    input  wire               pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty,
    output logic              full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [AW:0]       count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tslg_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage.
module tslg_divider #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 17
) (
    input  wire               aclk,
    input  wire               en,
    input  wire  [NUM_W-1:0]  num,
    input  wire  [DEN_W-1:0]  den,
    output logic [NUM_W-1:0]  quo
);

    logic [DEN_W-1:0] rem_reg  [0:NUM_W-1];
    logic [DEN_W-1:0] rem_next [0:NUM_W-1];
    logic [NUM_W-1:0] nq_reg   [0:NUM_W];
    logic [NUM_W-1:0] nq_next  [0:NUM_W];
    logic [DEN_W-1:0] d_reg    [0:NUM_W-1];

    assign quo = nq_reg[NUM_W];

    // The remainder stays below the divisor, so the trial value fits in DEN_W + 1 bits.
    always_comb begin
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;
        rem_next[0] = '0;
        nq_next[0]  = num;
        for (int i = 0; i < NUM_W; i++) begin
            trial = {rem_reg[i], nq_reg[i][NUM_W-1]};
            diff  = trial - {1'b0, d_reg[i]};
            ge    = (trial >= {1'b0, d_reg[i]});
            if (i < NUM_W - 1) begin
                rem_next[i+1] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            end
            nq_next[i+1] = {nq_reg[i][NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_W; i++) begin
                rem_reg[i] <= rem_next[i];
            end
            for (int i = 0; i <= NUM_W; i++) begin
                nq_reg[i] <= nq_next[i];
            end
            d_reg[0] <= den;
            for (int i = 1; i < NUM_W; i++) begin
                d_reg[i] <= d_reg[i-1];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/tslg_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tslg_back #(
    parameter int TEMP_BITS  = tslg_pkg::TEMP_BITS_DEF,
    parameter int WIDTH_BITS = tslg_pkg::WIDTH_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              fifo_empty,
    output logic                             pop,
    input  tslg_pkg::ctl_t                   ctl,
    input  wire  [4*TEMP_BITS-1:0]           mag_a,
    input  wire  [WIDTH_BITS:0]              den_a,
    input  wire  [4*TEMP_BITS-1:0]           mag_b,
    input  wire  [WIDTH_BITS:0]              den_b,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [tslg_pkg::SLOPE_W-1:0]     m_slope,
    output logic                             m_saturated
);

    localparam int QW = tslg_pkg::quo_bits(TEMP_BITS, WIDTH_BITS);
    localparam int NW = QW + 15;
    localparam int DB = WIDTH_BITS + 1;
    localparam int VW = QW + 2;
    localparam int EW = ((VW > tslg_pkg::SLOPE_W) ? VW : tslg_pkg::SLOPE_W) + 1;
    localparam logic signed [EW-1:0] SMAX =
        {{(EW - tslg_pkg::SLOPE_W + 1){1'b0}}, {(tslg_pkg::SLOPE_W - 1){1'b1}}};
    localparam logic signed [EW-1:0] SMIN = ~SMAX;

    logic en;
    logic out_valid_reg;

    assign en      = !out_valid_reg || m_ready;
    assign pop     = en && !fifo_empty;
    assign m_valid = out_valid_reg;

    // Adding half the divisor before the floor division rounds to nearest, ties up.
    logic [NW-1:0] sum_a, sum_b;
    logic [QW-1:0] quo_a, quo_b;

    assign sum_a = NW'(mag_a) + (NW'(den_a) << 14);
    assign sum_b = NW'(mag_b) + (NW'(den_b) << 14);

    tslg_divider #(.NUM_W(QW), .DEN_W(DB)) u_div_a (
        .aclk (aclk),
        .en   (en),
        .num  (sum_a[NW-1:15]),
        .den  (den_a),
        .quo  (quo_a)
    );

    tslg_divider #(.NUM_W(QW), .DEN_W(DB)) u_div_b (
        .aclk (aclk),
        .en   (en),
        .num  (sum_b[NW-1:15]),
        .den  (den_b),
        .quo  (quo_b)
    );

    logic           vld_reg [0:QW];
    tslg_pkg::ctl_t ctl_reg [0:QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= QW; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= !fifo_empty;
            for (int i = 1; i <= QW; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg[0] <= ctl;
            for (int i = 1; i <= QW; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // Stage 1: signed slopes. For a high vacuum side the limit is taken negative.
    logic [QW:0]            qa_x, qb_x, va_next, vb_next;
    logic [QW:0]            s1_va_reg, s1_vb_reg;
    logic [1:0]             s1_cls_reg;
    logic                   s1_valid_reg;

    assign qa_x    = {1'b0, quo_a};
    assign qb_x    = {1'b0, quo_b};
    assign va_next = ctl_reg[QW].neg_a ? -qa_x : qa_x;

    always_comb begin
        case (ctl_reg[QW].cls)
            tslg_pkg::CLS_INTERIOR: vb_next = ctl_reg[QW].neg_b ? -qb_x : qb_x;
            tslg_pkg::CLS_HIGH_VAC: vb_next = -qb_x;
            default:                vb_next = qb_x;
        endcase
    end

    // Stage 2: limit or sum; other cases give zero.
    logic signed [QW:0]     sva, svb;
    logic signed [VW-1:0]   ea, eb, r_next;
    logic signed [VW-1:0]   s2_r_reg;
    logic                   s2_half_reg;
    logic                   s2_valid_reg;

    assign sva = $signed(s1_va_reg);
    assign svb = $signed(s1_vb_reg);
    assign ea  = VW'(sva);
    assign eb  = VW'(svb);

    always_comb begin
        case (s1_cls_reg)
            tslg_pkg::CLS_LOW_VAC:  r_next = (sva > svb) ? eb : ea;
            tslg_pkg::CLS_HIGH_VAC: r_next = (sva < svb) ? eb : ea;
            tslg_pkg::CLS_INTERIOR: r_next = ea + eb;
            default:                r_next = '0;
        endcase
    end

    // Stage 3: halve the interior sum with ties away from zero, then saturate.
    logic signed [VW-1:0]   inc_sum, rnd;
    logic signed [EW-1:0]   ve;
    logic                   sat_hi, sat_lo;
    logic [tslg_pkg::SLOPE_W-1:0] out_slope_reg;
    logic                   out_sat_reg;

    assign inc_sum = s2_r_reg + (s2_r_reg[VW-1] ? VW'(0) : VW'(1));
    assign rnd     = s2_half_reg ? (inc_sum >>> 1) : s2_r_reg;
    assign ve      = EW'(rnd);
    assign sat_hi  = (ve > SMAX);
    assign sat_lo  = (ve < SMIN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg  <= vld_reg[QW];
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_va_reg   <= va_next;
            s1_vb_reg   <= vb_next;
            s1_cls_reg  <= ctl_reg[QW].cls;
            s2_r_reg    <= r_next;
            s2_half_reg <= (s1_cls_reg == tslg_pkg::CLS_INTERIOR);
            if (sat_hi) begin
                out_slope_reg <= SMAX[tslg_pkg::SLOPE_W-1:0];
            end else if (sat_lo) begin
                out_slope_reg <= SMIN[tslg_pkg::SLOPE_W-1:0];
            end else begin
                out_slope_reg <= ve[tslg_pkg::SLOPE_W-1:0];
            end
            out_sat_reg <= sat_hi || sat_lo;
        end
    end

    assign m_slope     = out_slope_reg;
    assign m_saturated = out_sat_reg;

endmodule

`default_nettype wire

// File: bench/t4_slope_limited_gradient_tb.sv
`timescale 1ns / 1ps

module t4_slope_limited_gradient_tb;

    localparam logic [tslg_pkg::KIND_W-1:0] KIND_REFLECT = 2'd2;
    localparam logic [tslg_pkg::KIND_W-1:0] KIND_SPARE   = 2'd3;
    localparam longint SLOPE_HI   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SLOPE_LO   = -SLOPE_HI - 1;
    localparam int     N_RANDOM   = 450;
    localparam int     STALL_LIMIT = 5000;
    localparam int     DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [tslg_pkg::FIELD_W-1:0] ct, lt, ht, cw, lw, hw;
        logic [tslg_pkg::KIND_W-1:0]  lk, hk;
    } cell_t;

    typedef struct packed {
        logic [tslg_pkg::SLOPE_W-1:0] slope;
        logic                         sat;
    } grad_t;

    typedef struct packed {
        cell_t c;
        bit    known;
        grad_t g;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [tslg_pkg::FIELD_W-1:0] s_cell_temp = '0, s_low_temp = '0, s_high_temp = '0;
    logic [tslg_pkg::FIELD_W-1:0] s_cell_width = '0, s_low_width = '0, s_high_width = '0;
    logic [tslg_pkg::KIND_W-1:0]  s_low_kind = '0, s_high_kind = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [tslg_pkg::SLOPE_W-1:0] m_slope;
    logic m_saturated;

    grad_t pending_slopes[$];
    int    fail_count = 0;
    int    quiet_cycles = 0;
    bit    quiet = 1'b0;

    t4_slope_limited_gradient uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cell_temp(s_cell_temp), .s_low_temp(s_low_temp), .s_high_temp(s_high_temp),
        .s_cell_width(s_cell_width), .s_low_width(s_low_width),
        .s_high_width(s_high_width),
        .s_low_kind(s_low_kind), .s_high_kind(s_high_kind),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_slope(m_slope), .m_saturated(m_saturated)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic longint unsigned fourth_power(input logic [tslg_pkg::FIELD_W-1:0] t);
        longint unsigned sq;
        sq = longint'(t) * longint'(t);
        return sq * sq;
    endfunction

    function automatic longint unsigned eff_width(input logic [tslg_pkg::FIELD_W-1:0] w);
        return (w == 0) ? 64'd1 : longint'(w);
    endfunction

    function automatic longint unsigned round_quot(input longint unsigned mag,
                                                   input longint unsigned den);
        longint unsigned q, r;
        q = mag / den;
        r = mag % den;
        if (2 * r >= den) q++;
        return q;
    endfunction

    // Slope from a to b over the mean of the two widths.
    function automatic longint edge_slope(input longint unsigned a, b, w1, w2);
        longint unsigned q;
        q = round_quot((b < a) ? a - b : b - a, (w1 + w2) << 15);
        return (b < a) ? -longint'(q) : longint'(q);
    endfunction

    function automatic grad_t t4_gradient(input cell_t c);
        longint unsigned t4c, wc;
        longint lim, ls, hs, s, v;
        grad_t g;
        t4c = fourth_power(c.ct);
        wc = eff_width(c.cw);
        v = 0;
        if (!(c.lk inside {tslg_pkg::KIND_INTERIOR, tslg_pkg::KIND_VACUUM}) ||
            !(c.hk inside {tslg_pkg::KIND_INTERIOR, tslg_pkg::KIND_VACUUM})) begin
            v = 0;
        end else if (c.lk == tslg_pkg::KIND_VACUUM && c.hk == tslg_pkg::KIND_VACUUM) begin
            v = 0;
        end else if (c.lk == tslg_pkg::KIND_VACUUM) begin
            lim = longint'(round_quot(t4c, wc << 15));
            v = edge_slope(t4c, fourth_power(c.ht), wc, eff_width(c.hw));
            if (v > lim) v = lim;
        end else if (c.hk == tslg_pkg::KIND_VACUUM) begin
            lim = longint'(round_quot(t4c, wc << 15));
            v = edge_slope(fourth_power(c.lt), t4c, wc, eff_width(c.lw));
            if (v < -lim) v = -lim;
        end else begin
            ls = edge_slope(fourth_power(c.lt), t4c, eff_width(c.lw), wc);
            hs = edge_slope(t4c, fourth_power(c.ht), wc, eff_width(c.hw));
            s = ls + hs;
            v = (s >= 0) ? (s + 1) / 2 : -((-s + 1) / 2);
        end
        g.sat = 1'b0;
        if (v > SLOPE_HI) begin
            v = SLOPE_HI;
            g.sat = 1'b1;
        end else if (v < SLOPE_LO) begin
            v = SLOPE_LO;
            g.sat = 1'b1;
        end
        g.slope = v[tslg_pkg::SLOPE_W-1:0];
        return g;
    endfunction

    function automatic logic [tslg_pkg::FIELD_W-1:0] rand_field();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return tslg_pkg::FIELD_W'($urandom_range(3));
            default: return tslg_pkg::FIELD_W'($urandom);
        endcase
    endfunction

    function automatic cell_t rand_cell();
        cell_t c;
        c.ct = rand_field(); c.lt = rand_field(); c.ht = rand_field();
        c.cw = rand_field(); c.lw = rand_field(); c.hw = rand_field();
        // Mostly interior and vacuum sides, since those reach the arithmetic.
        c.lk = ($urandom_range(9) < 8) ? tslg_pkg::KIND_W'($urandom_range(1))
                                       : tslg_pkg::KIND_W'($urandom);
        c.hk = ($urandom_range(9) < 8) ? tslg_pkg::KIND_W'($urandom_range(1))
                                       : tslg_pkg::KIND_W'($urandom);
        return c;
    endfunction

    // One transfer on the input side; valid stays high between back-to-back items.
    task automatic send_cell(input cell_t c, input grad_t g);
        while (!quiet && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_cell_temp, s_low_temp, s_high_temp, s_cell_width, s_low_width, s_high_width,
         s_low_kind, s_high_kind} <= c;
        do @(posedge aclk); while (!s_ready);
        pending_slopes.push_back(g);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_slopes.size() == 0) begin
                    $display("%0t: result with nothing expected: slope %h sat %b",
                             $time, m_slope, m_saturated);
                    fail_count++;
                end else begin
                    grad_t e;
                    e = pending_slopes.pop_front();
                    if (m_slope !== e.slope) begin
                        $display("%0t: slope expected %h actual %h", $time, e.slope, m_slope);
                        fail_count++;
                    end
                    if (m_saturated !== e.sat) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, e.sat, m_saturated);
                        fail_count++;
                    end
                end
            end
            m_ready <= quiet || ($urandom_range(99) >= 19);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (aresetn) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    row_t directed[] = '{
        '{'{16'h8000, 16'h1000, 16'hFFFF, 16'h0100, 16'h0100, 16'h0100,
            KIND_REFLECT, tslg_pkg::KIND_INTERIOR}, 1'b1, '{48'h0, 1'b0}},
        '{'{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h0001, 16'h0001,
            tslg_pkg::KIND_INTERIOR, KIND_REFLECT}, 1'b1, '{48'h0, 1'b0}},
        '{'{16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0001,
            tslg_pkg::KIND_VACUUM, tslg_pkg::KIND_VACUUM}, 1'b1, '{48'h0, 1'b0}},
        '{'{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
            KIND_SPARE, tslg_pkg::KIND_INTERIOR}, 1'b1, '{48'h0, 1'b0}},
        '{'{16'h1234, 16'h0000, 16'hFFFF, 16'h0100, 16'h0100, 16'h0100,
            tslg_pkg::KIND_VACUUM, KIND_SPARE}, 1'b1, '{48'h0, 1'b0}},
        // A cold cell next to vacuum is limited to a flat slope.
        '{'{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001,
            tslg_pkg::KIND_VACUUM, tslg_pkg::KIND_INTERIOR}, 1'b1, '{48'h0, 1'b0}},
        '{'{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001,
            tslg_pkg::KIND_INTERIOR, tslg_pkg::KIND_VACUUM}, 1'b1, '{48'h0, 1'b0}},
        '{'{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
            tslg_pkg::KIND_INTERIOR, tslg_pkg::KIND_INTERIOR}, 1'b1, '{48'h0, 1'b0}},
        '{'{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            tslg_pkg::KIND_INTERIOR, tslg_pkg::KIND_VACUUM}, 1'b0, '0},
        '{'{16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0001,
            tslg_pkg::KIND_VACUUM, tslg_pkg::KIND_INTERIOR}, 1'b0, '0},
        '{'{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
            tslg_pkg::KIND_INTERIOR, tslg_pkg::KIND_INTERIOR}, 1'b0, '0},
        '{'{16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0001, 16'h0001,
            tslg_pkg::KIND_INTERIOR, tslg_pkg::KIND_INTERIOR}, 1'b0, '0},
        '{'{16'h4000, 16'h3000, 16'h5000, 16'h0100, 16'h0080, 16'h0200,
            tslg_pkg::KIND_INTERIOR, tslg_pkg::KIND_INTERIOR}, 1'b0, '0},
        '{'{16'h4000, 16'h3000, 16'hFFFF, 16'h0100, 16'h0080, 16'hFFFF,
            tslg_pkg::KIND_VACUUM, tslg_pkg::KIND_INTERIOR}, 1'b0, '0},
        '{'{16'h4000, 16'h5000, 16'h0000, 16'h0100, 16'h0080, 16'h0200,
            tslg_pkg::KIND_VACUUM, tslg_pkg::KIND_INTERIOR}, 1'b0, '0},
        '{'{16'h4000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0200,
            tslg_pkg::KIND_INTERIOR, tslg_pkg::KIND_VACUUM}, 1'b0, '0},
        '{'{16'h4000, 16'h0000, 16'h0000, 16'h0100, 16'h0001, 16'h0200,
            tslg_pkg::KIND_INTERIOR, tslg_pkg::KIND_VACUUM}, 1'b0, '0},
        '{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
            tslg_pkg::KIND_INTERIOR, tslg_pkg::KIND_INTERIOR}, 1'b0, '0}
    };

    initial begin
        cell_t c;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) begin
            send_cell(directed[i].c,
                      directed[i].known ? directed[i].g : t4_gradient(directed[i].c));
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= 150 && n < 230);
            if (n == 300) begin
                // Let the pipeline drain completely before going on.
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_slopes.size() != 0) @(posedge aclk);
            end
            c = rand_cell();
            send_cell(c, t4_gradient(c));
        end
        quiet = 1'b0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_slopes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
